@@ hw/rtl/mtem_pkg.sv @@
`default_nettype none

package mtem_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 12;
    localparam int CFG_W      = 16;
    localparam int UNITY_GAIN = 32768;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int FRAC_BITS  = 15;

    // Operand source for one product term
    typedef enum logic [1:0] {
        SRC_MEM,    // delay-line read data
        SRC_CUR,    // current input sample
        SRC_ZERO    // entry never written since reset
    } t_src;

    // One multiply-accumulate step, issued once per cycle unless the datapath is held
    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       last;
        t_src                       src;
        logic [GAIN_W-1:0]          gain;
        logic signed [SAMPLE_W-1:0] cur;
    } t_mac_op;

    // Finished mix, valid for one cycle unless held
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_mac_res;

endpackage

`default_nettype wire

@@ hw/rtl/multi_tap_echo_mixer.sv @@
// Each accepted sample runs as a direct-path step, then one step per tap, through r_op,
//   the RAM read register, r_prod and r_acc into the output register. The next sample
//   is taken as the last step issues: one RAM read port, one shared multiplier.
// Reset: synchronous, active low; gains/delays return to defaults, the write pointer
//   and fill count clear. The delay line itself is not swept: entries beyond the
//   fill count read as zero, so the block is ready the cycle after reset.
`default_nettype none

module multi_tap_echo_mixer #(
    parameter int MAX_DELAY = 4096,
    parameter int NUM_TAPS  = 3
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input sample channel
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [mtem_pkg::SAMPLE_W-1:0]   i_in_sample,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [mtem_pkg::SAMPLE_W-1:0]        o_mix_sample,
    output logic                                        o_clipped,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [$clog2(2*NUM_TAPS+1)-1:0]        i_cfg_idx,
    input  wire logic [mtem_pkg::CFG_W-1:0]             i_cfg_data
);

    localparam int AW  = $clog2(MAX_DELAY);
    localparam int CW  = (AW > mtem_pkg::DELAY_W ? AW : mtem_pkg::DELAY_W) + 1;
    localparam int SW  = $clog2(NUM_TAPS + 1);
    localparam int TW  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int IW  = $clog2(2*NUM_TAPS + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Gains above unity are clamped on write.
    // ------------------------------------------------------------------
    logic [mtem_pkg::GAIN_W-1:0]  r_direct_gain;
    logic [mtem_pkg::GAIN_W-1:0]  r_tap_gain  [NUM_TAPS];
    logic [mtem_pkg::DELAY_W-1:0] r_tap_delay [NUM_TAPS];
    logic [mtem_pkg::GAIN_W-1:0]  cfg_gain;

    assign cfg_gain = (i_cfg_data > mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN))
                    ? mtem_pkg::GAIN_W'(mtem_pkg::UNITY_GAIN)
                    : i_cfg_data[mtem_pkg::GAIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct_gain <= mtem_pkg::GAIN_W'(mtem_pkg::UNITY_GAIN);
            for (int k = 0; k < NUM_TAPS; k++) begin
                r_tap_gain[k]  <= '0;
                r_tap_delay[k] <= '0;
            end
        end else if (i_cfg_we) begin
            // index 0: direct gain; 2k+1: tap k delay; 2k+2: tap k gain
            if (i_cfg_idx == IW'(0)) begin
                r_direct_gain <= cfg_gain;
            end
            for (int k = 0; k < NUM_TAPS; k++) begin
                if (i_cfg_idx == IW'(2*k + 1)) begin
                    r_tap_delay[k] <= i_cfg_data[mtem_pkg::DELAY_W-1:0];
                end
                if (i_cfg_idx == IW'(2*k + 2)) begin
                    r_tap_gain[k] <= cfg_gain;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Delay-line bookkeeping. The new sample is written at accept time to
    // the write pointer; taps of this item never read that slot (delay
    // >= 1), and the RAM is read-first, so no forwarding is needed.
    // r_fill counts samples written since reset (saturating). An entry
    // d back is valid only when d < r_fill, otherwise it reads as zero.
    // ------------------------------------------------------------------
    logic [AW-1:0]                        r_wp;
    logic [AW-1:0]                        r_wp_cur;
    logic [AW:0]                          r_fill;
    logic signed [mtem_pkg::SAMPLE_W-1:0] r_x;
    logic                                 r_active;
    logic [SW-1:0]                        r_step;
    mtem_pkg::t_mac_op                    r_op;

    logic                                 accept;
    logic                                 hold;
    logic                                 adv;
    logic                                 last_step;
    logic                                 is_direct;
    logic [TW-1:0]                        tap_idx;
    logic [CW-1:0]                        d_ext;
    logic [AW-1:0]                        d_eff;
    logic [AW:0]                          diff;
    logic [AW-1:0]                        raddr;
    logic [AW-1:0]                        n_wp;
    mtem_pkg::t_mac_op                    n_op;
    mtem_pkg::t_mac_res                   res;
    logic signed [mtem_pkg::SAMPLE_W-1:0] rdata;

    // Step 0 handles the direct path, step k+1 handles tap k.
    assign is_direct = (r_step == SW'(0));
    assign last_step = (r_step == SW'(NUM_TAPS));
    assign tap_idx   = TW'(r_step - SW'(1));

    always_comb begin
        d_ext = CW'(r_tap_delay[tap_idx]);
        if (d_ext >= CW'(MAX_DELAY)) begin
            d_ext = CW'(MAX_DELAY - 1);
        end
        d_eff = AW'(d_ext);

        // circular address: wp - d, wrapped by MAX_DELAY
        diff = {1'b0, r_wp_cur} - {1'b0, d_eff};
        if (diff[AW]) begin
            raddr = AW'(diff + (AW+1)'(MAX_DELAY));
        end else begin
            raddr = AW'(diff);
        end

        n_op.valid = r_active;
        n_op.first = is_direct;
        n_op.last  = last_step;
        n_op.cur   = r_x;
        if (is_direct) begin
            n_op.gain = r_direct_gain;
            n_op.src  = mtem_pkg::SRC_CUR;
        end else begin
            n_op.gain = r_tap_gain[tap_idx];
            if (d_eff == AW'(0)) begin
                n_op.src = mtem_pkg::SRC_CUR;
            end else if ({1'b0, d_eff} < r_fill) begin
                n_op.src = mtem_pkg::SRC_MEM;
            end else begin
                n_op.src = mtem_pkg::SRC_ZERO;
            end
        end
    end

    assign n_wp = (r_wp == AW'(MAX_DELAY - 1)) ? '0 : r_wp + AW'(1);

    // The whole datapath freezes when a finished mix meets a full, stalled
    // output register. The next transaction is taken as the previous one
    // issues its last step.
    assign hold    = res.valid && o_valid && i_stall;
    assign adv     = !hold;
    assign o_stall = hold || (r_active && !last_step);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_active <= 1'b0;
            r_step   <= '0;
            r_op     <= '0;
        end else begin
            if (accept) begin
                r_wp     <= n_wp;
                r_active <= 1'b1;
                r_step   <= '0;
                if (r_fill != (AW+1)'(MAX_DELAY)) begin
                    r_fill <= r_fill + (AW+1)'(1);
                end
            end else if (adv && r_active) begin
                if (last_step) begin
                    r_active <= 1'b0;
                end else begin
                    r_step <= r_step + SW'(1);
                end
            end
            if (adv) begin
                r_op <= n_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x      <= i_in_sample;
            r_wp_cur <= r_wp;
        end
    end

    mtem_ram #(
        .WIDTH (mtem_pkg::SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (i_in_sample),
        .i_re    (adv),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mtem_mac #(
        .NUM_TAPS (NUM_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_op    (r_op),
        .i_rdata (rdata),
        .o_res   (res)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                                 r_out_valid;
    logic signed [mtem_pkg::SAMPLE_W-1:0] r_mix;
    logic                                 r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && adv) begin
            r_mix  <= res.sample;
            r_clip <= res.clipped;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mix_sample = r_mix;
    assign o_clipped    = r_clip;

endmodule

`default_nettype wire

@@ hw/rtl/mtem_ram.sv @@
`default_nettype none

// Simple dual-port RAM, registered read-first output.
module mtem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/mtem_mac.sv @@
`default_nettype none

// Shared multiplier, floor shift, accumulate and saturate.
module mtem_mac #(
    parameter int NUM_TAPS = 3
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_adv,
    input  wire mtem_pkg::t_mac_op                    i_op,
    input  wire logic signed [mtem_pkg::SAMPLE_W-1:0] i_rdata,
    output mtem_pkg::t_mac_res                        o_res
);

    localparam int PROD_W = mtem_pkg::GAIN_W + 1 + mtem_pkg::SAMPLE_W;
    localparam int TERM_W = PROD_W - mtem_pkg::FRAC_BITS;
    localparam int ACC_W  = TERM_W + $clog2(NUM_TAPS + 1);
    localparam logic signed [ACC_W-1:0] HI = ACC_W'(mtem_pkg::SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] LO = ACC_W'(mtem_pkg::SAMPLE_MIN);

    logic                                 r_valid;
    logic                                 r_first;
    logic                                 r_last;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [ACC_W-1:0]              r_acc;

    logic signed [mtem_pkg::SAMPLE_W-1:0] sel_sample;
    logic signed [PROD_W-1:0]             n_prod;
    logic signed [TERM_W-1:0]             term;
    logic signed [ACC_W-1:0]              n_acc;

    always_comb begin
        case (i_op.src)
            mtem_pkg::SRC_MEM: sel_sample = i_rdata;
            mtem_pkg::SRC_CUR: sel_sample = i_op.cur;
            default:           sel_sample = '0;
        endcase
        n_prod = $signed({1'b0, i_op.gain}) * sel_sample;
    end

    // arithmetic shift right by 15 = floor
    assign term  = r_prod[PROD_W-1:mtem_pkg::FRAC_BITS];
    assign n_acc = (r_first ? ACC_W'(0) : r_acc) + ACC_W'(term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_op.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_first <= i_op.first;
            r_last  <= i_op.last;
            r_prod  <= n_prod;
            if (r_valid) begin
                r_acc <= n_acc;
            end
        end
    end

    always_comb begin
        o_res.valid   = r_valid && r_last;
        o_res.clipped = 1'b0;
        if (n_acc > HI) begin
            o_res.sample  = mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MAX);
            o_res.clipped = 1'b1;
        end else if (n_acc < LO) begin
            o_res.sample  = mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MIN);
            o_res.clipped = 1'b1;
        end else begin
            o_res.sample  = n_acc[mtem_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ verif/multi_tap_echo_mixer_tb.sv @@
`timescale 1ns / 100ps

module multi_tap_echo_mixer_tb;

    localparam int TAPS         = 3;
    localparam int DEPTH        = 4096;
    localparam int LATENCY      = TAPS + 3;  // input transaction to result
    localparam int SETTLE       = LATENCY + 4;
    localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
    localparam int QUIET_LIMIT  = 4000;      // cycles with no transaction at all
    localparam int ROUNDS       = 8;
    localparam int ROUND_ITEMS  = 185;

    // Register map, index order of the configuration port
    typedef enum logic [2:0] {
        REG_DIRECT_GAIN,
        REG_TAP0_DELAY,
        REG_TAP0_GAIN,
        REG_TAP1_DELAY,
        REG_TAP1_GAIN,
        REG_TAP2_DELAY,
        REG_TAP2_GAIN,
        REG_UNUSED      // no register here; writes must be dropped
    } t_mix_reg;

    typedef struct {
        logic signed [mtem_pkg::SAMPLE_W-1:0] mix;
        logic                                 clip;
    } t_mix_out;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_stall;
    logic signed [mtem_pkg::SAMPLE_W-1:0] i_in_sample = '0;
    logic                                 o_valid;
    logic                                 i_stall     = 1'b0;
    logic signed [mtem_pkg::SAMPLE_W-1:0] o_mix_sample;
    logic                                 o_clipped;
    logic                                 i_cfg_we    = 1'b0;
    logic [2:0]                           i_cfg_idx   = '0;
    logic [mtem_pkg::CFG_W-1:0]           i_cfg_data  = '0;

    multi_tap_echo_mixer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_sample  (i_in_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mix_sample (o_mix_sample),
        .o_clipped    (o_clipped),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Mixer model: its own copy of the registers and the delay line
    // ------------------------------------------------------------------
    logic [mtem_pkg::GAIN_W-1:0]          dir_gain = mtem_pkg::GAIN_W'(mtem_pkg::UNITY_GAIN);
    logic [mtem_pkg::DELAY_W-1:0]         tap_dly [TAPS] = '{default: '0};
    logic [mtem_pkg::GAIN_W-1:0]          tap_gn  [TAPS] = '{default: '0};
    logic signed [mtem_pkg::SAMPLE_W-1:0] echo_line [DEPTH] = '{default: '0};
    logic [mtem_pkg::DELAY_W-1:0]         line_wr_pos = '0;

    t_mix_out                             mix_expect_q [$];
    logic signed [mtem_pkg::SAMPLE_W-1:0] sample_q [$];   // samples waiting for the driver

    int n_in       = 0;
    int n_out      = 0;
    int n_clip     = 0;
    int n_cfg      = 0;
    int n_settings = 0;
    int err_count  = 0;

    // Gain times sample, floor-shifted back to Q1.15. Gains past unity clamp.
    function automatic longint tap_term(
        input logic [mtem_pkg::GAIN_W-1:0]          gain,
        input logic signed [mtem_pkg::SAMPLE_W-1:0] smp
    );
        longint g;
        longint p;
        g = (gain > mtem_pkg::UNITY_GAIN) ? longint'(mtem_pkg::UNITY_GAIN)
                                          : longint'(gain);
        p = g * smp;
        return p >>> mtem_pkg::FRAC_BITS;
    endfunction

    // One sample in, one mix out; advances the delay line.
    function automatic void mix_predict(input logic signed [mtem_pkg::SAMPLE_W-1:0] x);
        longint                               acc;
        logic signed [mtem_pkg::SAMPLE_W-1:0] tapped;
        logic [mtem_pkg::DELAY_W-1:0]         rd_pos;
        t_mix_out                             res;
        acc = tap_term(dir_gain, x);
        // Delays are 12 bits wide, so they never reach the line length and
        // no clamp is needed; the 12-bit subtraction wraps like the ring.
        for (int k = 0; k < TAPS; k++) begin
            if (tap_dly[k] == '0) begin
                tapped = x;     // zero delay taps the sample arriving now
            end else begin
                rd_pos = line_wr_pos - tap_dly[k];
                tapped = echo_line[rd_pos];
            end
            acc += tap_term(tap_gn[k], tapped);
        end
        res.clip = (acc > mtem_pkg::SAMPLE_MAX) || (acc < mtem_pkg::SAMPLE_MIN);
        if (acc > mtem_pkg::SAMPLE_MAX) begin
            res.mix = mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MAX);
        end else if (acc < mtem_pkg::SAMPLE_MIN) begin
            res.mix = mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MIN);
        end else begin
            res.mix = acc[mtem_pkg::SAMPLE_W-1:0];
        end
        echo_line[line_wr_pos] = x;
        line_wr_pos            = line_wr_pos + 1'b1;
        if (res.clip) n_clip++;
        mix_expect_q.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d: %s got %0d, want %0d", n_out, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Traffic shaping knobs, changed by the sequence only at a rising edge
    // ------------------------------------------------------------------
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic long_hold      = 1'b0;
    int   hold_cnt       = 0;
    logic in_taken       = 1'b0;  // sample transaction completed at last edge

    // Driver: new sample only once the previous one was taken; a stalled
    // sample stays put. Inputs move on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid     <= 1'b1;
                i_in_sample <= sample_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted right here
    always @(negedge i_clk) begin
        if (long_hold && hold_cnt < HOLD_CYCLES) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (!long_hold) hold_cnt <= 0;
        end
    end

    // Monitor: register writes, sample transactions and result checks, all
    // sampled at the rising edge.
    always @(posedge i_clk) begin
        t_mix_out want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (i_cfg_we) begin
                case (t_mix_reg'(i_cfg_idx))
                    REG_DIRECT_GAIN: dir_gain   = i_cfg_data;
                    REG_TAP0_DELAY:  tap_dly[0] = i_cfg_data[mtem_pkg::DELAY_W-1:0];
                    REG_TAP0_GAIN:   tap_gn[0]  = i_cfg_data;
                    REG_TAP1_DELAY:  tap_dly[1] = i_cfg_data[mtem_pkg::DELAY_W-1:0];
                    REG_TAP1_GAIN:   tap_gn[1]  = i_cfg_data;
                    REG_TAP2_DELAY:  tap_dly[2] = i_cfg_data[mtem_pkg::DELAY_W-1:0];
                    REG_TAP2_GAIN:   tap_gn[2]  = i_cfg_data;
                    default: ;      // unmapped index: dropped
                endcase
            end
            if (i_valid && !o_stall) begin
                n_in++;
                mix_predict(i_in_sample);
            end
            if (o_valid && !i_stall) begin
                if (mix_expect_q.size() == 0) begin
                    report_mismatch("result with no sample pending", o_mix_sample, 0);
                end else begin
                    want = mix_expect_q.pop_front();
                    if (o_mix_sample !== want.mix)
                        report_mismatch("mix_sample", o_mix_sample, want.mix);
                    if (o_clipped !== want.clip)
                        report_mismatch("clipped", o_clipped, want.clip);
                end
                n_out++;
            end
        end
    end

    // Watchdog: any transaction on either channel resets the count
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, mix_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input t_mix_reg idx, input logic [mtem_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Full register set; also pokes the unmapped index with junk now and then
    task automatic program_mixer(input logic [mtem_pkg::CFG_W-1:0] dg,
                                 input logic [mtem_pkg::CFG_W-1:0] d0,
                                 input logic [mtem_pkg::CFG_W-1:0] g0,
                                 input logic [mtem_pkg::CFG_W-1:0] d1,
                                 input logic [mtem_pkg::CFG_W-1:0] g1,
                                 input logic [mtem_pkg::CFG_W-1:0] d2,
                                 input logic [mtem_pkg::CFG_W-1:0] g2);
        write_reg(REG_DIRECT_GAIN, dg);
        write_reg(REG_TAP0_DELAY, d0);
        write_reg(REG_TAP0_GAIN, g0);
        if ($urandom_range(0, 1)) write_reg(REG_UNUSED, mtem_pkg::CFG_W'($urandom()));
        write_reg(REG_TAP1_DELAY, d1);
        write_reg(REG_TAP1_GAIN, g1);
        write_reg(REG_TAP2_DELAY, d2);
        write_reg(REG_TAP2_GAIN, g2);
        n_settings++;
    endtask

    // Sender stays quiet until every result is back, then while the block settles
    task automatic wait_drained();
        @(negedge i_clk);
        while (sample_q.size() > 0 || i_valid || mix_expect_q.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_traffic(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [mtem_pkg::CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN);
            2:       return mtem_pkg::CFG_W'($urandom_range(mtem_pkg::UNITY_GAIN + 1,
                                                            65535)); // clamps
            default: return mtem_pkg::CFG_W'($urandom_range(0, mtem_pkg::UNITY_GAIN));
        endcase
    endfunction

    // Upper nibble is random junk above the 12-bit delay field
    function automatic logic [mtem_pkg::CFG_W-1:0] pick_delay();
        logic [3:0]                   junk;
        logic [mtem_pkg::DELAY_W-1:0] d;
        junk = 4'($urandom());
        case ($urandom_range(0, 5))
            0:       d = '0;
            1:       d = '1;
            2:       d = mtem_pkg::DELAY_W'($urandom_range(0, DEPTH - 1));
            default: d = mtem_pkg::DELAY_W'($urandom_range(1, 48)); // short, so echoes overlap
        endcase
        return {junk, d};
    endfunction

    function automatic logic signed [mtem_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MAX);
            1:       return mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MIN);
            2:       return mtem_pkg::SAMPLE_W'($urandom_range(0, 511) - 256);
            3:       return '0;
            default: return mtem_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int                         len;
        int                         pushed;
        logic [mtem_pkg::CFG_W-1:0] d0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: unity direct path, all taps off
        set_traffic(0, 0);
        sample_q = '{mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MAX),
                     mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MIN),
                     16'sd0, -16'sd1, 16'sd1};
        wait_drained();

        // Zero-delay tap doubles the current sample (clips at both ends),
        // an over-unity gain clamps, two taps share a delay, and a write to
        // the unmapped index must leave everything alone.
        write_reg(REG_DIRECT_GAIN, mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN));
        write_reg(REG_TAP0_DELAY, '0);
        write_reg(REG_TAP0_GAIN, mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN));
        write_reg(REG_TAP1_DELAY, 16'd2);
        write_reg(REG_TAP1_GAIN, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_TAP2_DELAY, 16'd2);
        write_reg(REG_TAP2_GAIN, 16'd16384);
        n_settings++;
        set_traffic(0, 0);
        sample_q = '{mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MAX),
                     mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MIN), 16'sd16384, -16'sd16385,
                     16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sh5555, -16'sh5556, 16'sd0, 16'sd0};
        wait_drained();

        // All gains zero: output must be silent
        program_mixer('0, '0, '0, 16'hFFF, '0, 16'd1, '0);
        set_traffic(0, 0);
        sample_q = '{mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MAX),
                     mtem_pkg::SAMPLE_W'(mtem_pkg::SAMPLE_MIN), 16'sd1234};
        wait_drained();

        // Random rounds, each with its own register setting and traffic mix
        for (int r = 0; r < ROUNDS; r++) begin
            case (r)
                0: program_mixer(16'hFFFF, 16'hFFF, mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN),
                                 16'd1, 16'hFFFF,
                                 16'd0, mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN));
                ROUNDS - 1: program_mixer(mtem_pkg::CFG_W'(mtem_pkg::UNITY_GAIN), 16'd1,
                                          16'd1, 16'hFFF, 16'd1, 16'd1, 16'd1);
                default: begin
                    // Reuse one delay now and then so taps stack up
                    d0 = pick_delay();
                    program_mixer(pick_gain(), d0, pick_gain(),
                                  $urandom_range(0, 3) == 0 ? d0 : pick_delay(), pick_gain(),
                                  pick_delay(), pick_gain());
                end
            endcase

            case (r % 4)
                0: set_traffic(0, 0);
                1: set_traffic(85, 0);
                2: set_traffic(0, 85);
                default: set_traffic(36, 36);
            endcase

            // Bursts of program material, broken up by silence that flushes
            // the echo tail
            pushed = 0;
            while (pushed < ROUND_ITEMS) begin
                if ($urandom_range(0, 5) == 0) begin
                    len = $urandom_range(3, 20);
                    repeat (len) sample_q.push_back('0);
                end else begin
                    len = $urandom_range(1, 25);
                    repeat (len) sample_q.push_back(pick_sample());
                end
                pushed += len;
            end

            // One round with a busy sender and a receiver that holds off
            // long enough for the block to fill and push back on its input
            if (r == 4) begin
                long_hold = 1'b1;
                while (hold_cnt < HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            wait_drained();
        end

        $display("Covered %0d samples and %0d checked mixes (%0d clipped)",
                 n_in, n_out, n_clip);
        $display("over %0d register settings and %0d register writes, %0d mismatches",
                 n_settings, n_cfg, err_count);
        if (err_count == 0 && mix_expect_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
